// File: hdl/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants of the batch merge sorter
// Holds the batch capacity, the data width and the transaction structs of the
// input and result channels.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Batch capacity and element width.
  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;

  // Index into a store, and a count that can also hold MAX_ITEMS itself.
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // One input transaction: an element and the end-of-batch marker.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } in_t;

  // One result transaction: a sorted element with its markers.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_res;
    logic                         last_res;
    logic                         overflow;
  } out_t;

endpackage

// File: hdl/bms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_ram: generic RAM with one write port and two registered read ports
// Both read ports deliver registered data in the cycle after the address.
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hdl/batch_merge_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_merge_sorter: stable ascending merge sort of a batch of signed values
// Loads a batch, sorts it with bottom-up merge passes between two RAM banks,
// and streams the sorted batch out.
// ----------------------------------------------------------------------------
// A batch is written one element per accepted transaction (start high while
// busy is low); unmarked elements can be taken back to back. The marked
// element starts the sort and busy stays high until the whole batch has been
// issued. Each merge pass moves every element once, with a setup step before
// each run pair, and there are ceil(log2 n) passes, all run by the single
// shared comparator that moves one element per cycle outside the setup steps,
// from the source bank to the destination bank. The results then come out one
// per cycle on res_o, each marked by res_valid_o for one cycle; the receiver
// cannot stall, so results must be taken as they appear. Elements beyond the
// capacity are dropped and flag overflow on every result of that batch.
// ----------------------------------------------------------------------------
module batch_merge_sorter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bms_pkg::in_t  in_i,
  output logic          busy,
  output logic          res_valid_o,
  output bms_pkg::out_t res_o
);

  import bms_pkg::*;

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEG  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] width_q, width_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] a_q, a_d;
  logic [CNT_W-1:0] b_q, b_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic             src_q, src_d;
  logic             emit_q, emit_d;
  logic             emit_last_q, emit_last_d;
  logic             emit_ovf_q, emit_ovf_d;

  // Bank ports.
  logic                  we0, we1;
  logic [IDX_W-1:0]      waddr0, waddr1;
  logic [DATA_WIDTH-1:0] wdata0, wdata1;
  logic [DATA_WIDTH-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [DATA_WIDTH-1:0] rd_a, rd_b;

  // Segment bounds and merge decision.
  logic [CNT_W:0]   mid_sum, hi_sum, width_dbl;
  logic [CNT_W-1:0] cnt_next, k_inc;
  logic             take_a;
  logic [DATA_WIDTH-1:0] merge_data;

  assign busy = (state_q != ST_IDLE);

  // Read data of the current source bank.
  assign rd_a = src_q ? rd1_a : rd0_a;
  assign rd_b = src_q ? rd1_b : rd0_b;

  // Shared comparator: take the left run unless it is used up or larger.
  assign take_a = (a_q < mid_q)
                  && ((b_q >= hi_q) || ($signed(rd_a) <= $signed(rd_b)));
  assign merge_data = take_a ? rd_a : rd_b;

  // Run boundaries for the next pair, clipped to the batch size.
  assign mid_sum   = {1'b0, k_q} + {1'b0, width_q};
  assign hi_sum    = {1'b0, k_q} + {width_q, 1'b0};
  assign width_dbl = {width_q, 1'b0};
  assign k_inc     = k_q + 1'b1;
  assign cnt_next  = (cnt_q < CNT_W'(MAX_ITEMS)) ? cnt_q + 1'b1 : cnt_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    width_d     = width_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    src_d       = src_q;
    emit_d      = 1'b0;
    emit_last_d = emit_last_q;
    emit_ovf_d  = emit_ovf_q;
    we0         = 1'b0;
    we1         = 1'b0;
    waddr0      = cnt_q[IDX_W-1:0];
    waddr1      = k_q[IDX_W-1:0];
    wdata0      = in_i.value;
    wdata1      = merge_data;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            we0   = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.last) begin
            src_d   = 1'b0;
            k_d     = '0;
            width_d = CNT_W'(1);
            if (cnt_next > CNT_W'(1)) begin
              state_d = ST_SEG;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end

      // Set up the next run pair and fetch its heads.
      ST_SEG: begin
        mid_d   = (mid_sum > {1'b0, cnt_q}) ? cnt_q : mid_sum[CNT_W-1:0];
        hi_d    = (hi_sum > {1'b0, cnt_q}) ? cnt_q : hi_sum[CNT_W-1:0];
        a_d     = k_q;
        b_d     = mid_d;
        state_d = ST_CMP;
      end

      // Move one element to the destination bank per cycle.
      ST_CMP: begin
        if (src_q) begin
          we0    = 1'b1;
          waddr0 = k_q[IDX_W-1:0];
          wdata0 = merge_data;
        end else begin
          we1 = 1'b1;
        end
        if (take_a) begin
          a_d = a_q + 1'b1;
        end else begin
          b_d = b_q + 1'b1;
        end
        k_d = k_inc;
        if (k_inc == cnt_q) begin
          k_d     = '0;
          src_d   = ~src_q;
          width_d = width_dbl[CNT_W-1:0];
          if (width_dbl >= {1'b0, cnt_q}) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SEG;
          end
        end else if (k_inc == hi_q) begin
          state_d = ST_SEG;
        end
      end

      // Read the sorted batch out, one element per cycle.
      ST_OUT: begin
        a_d         = k_q;
        k_d         = k_inc;
        emit_d      = 1'b1;
        emit_last_d = (k_inc == cnt_q);
        emit_ovf_d  = drop_q;
        if (k_inc == cnt_q) begin
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      emit_q  <= 1'b0;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      emit_q  <= emit_d;
      src_q   <= src_d;
    end
  end

  // Pointer and marker registers.
  always_ff @(posedge clk_i) begin
    width_q     <= width_d;
    k_q         <= k_d;
    a_q         <= a_d;
    b_q         <= b_d;
    mid_q       <= mid_d;
    hi_q        <= hi_d;
    emit_last_q <= emit_last_d;
    emit_ovf_q  <= emit_ovf_d;
  end

  // Element bank: loaded with the batch, then alternates with the scratch bank.
  bms_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ITEMS)
  ) u_bank0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr0),
    .wdata_i  (wdata0),
    .raddr_a_i(a_d[IDX_W-1:0]),
    .raddr_b_i(b_d[IDX_W-1:0]),
    .rdata_a_o(rd0_a),
    .rdata_b_o(rd0_b)
  );

  // Scratch bank.
  bms_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ITEMS)
  ) u_bank1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr1),
    .wdata_i  (wdata1),
    .raddr_a_i(a_d[IDX_W-1:0]),
    .raddr_b_i(b_d[IDX_W-1:0]),
    .rdata_a_o(rd1_a),
    .rdata_b_o(rd1_b)
  );

  // Result transaction, straight from the registered bank read.
  assign res_valid_o     = emit_q;
  assign res_o.value_res = rd_a;
  assign res_o.last_res  = emit_last_q;
  assign res_o.overflow  = emit_ovf_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the batch merge sorter
// Sends batches of signed values, first from a short directed table and then
// at random, and keeps its own sorted copy of every batch to check each result
// transaction in order. Random start gaps, full and overflowing batches, and
// drains of pending results are part of the run.
// ----------------------------------------------------------------------------
module tb;
  import bms_pkg::*;

  localparam int ITEM_TARGET = 470;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;

  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // One row of the directed table; lit holds a result typed in by hand.
  typedef struct {
    in_t  item;
    bit   has_lit;
    out_t lit;
  } row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  in_t  in_i = '0;
  logic busy;
  logic res_valid_o;
  out_t res_o;

  // Model state: the batch being collected and the sorted results still due.
  logic signed [DATA_WIDTH-1:0] held_vals [MAX_ITEMS];
  int   held_cnt = 0;
  bit   held_dropped = 1'b0;
  out_t sorted_q[$];

  int   mismatch_cnt = 0;
  int   stall_cnt = 0;

  batch_merge_sorter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .in_i       (in_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Store one accepted element; on the marked one, sort the batch and queue
  // every sorted element as an expected result.
  task automatic take_element(input in_t item);
    logic signed [DATA_WIDTH-1:0] key;
    out_t res;
    int   j;
    if (held_cnt < MAX_ITEMS) begin
      held_vals[held_cnt] = item.value;
      held_cnt++;
    end else begin
      held_dropped = 1'b1;
    end
    if (item.last) begin
      // Stable insertion sort; equal values cannot be told apart anyway.
      for (int i = 1; i < held_cnt; i++) begin
        key = held_vals[i];
        j = i - 1;
        while (j >= 0 && held_vals[j] > key) begin
          held_vals[j+1] = held_vals[j];
          j--;
        end
        held_vals[j+1] = key;
      end
      for (int i = 0; i < held_cnt; i++) begin
        res.value_res = held_vals[i];
        res.last_res  = (i == held_cnt - 1);
        res.overflow  = held_dropped;
        sorted_q.push_back(res);
      end
      held_cnt = 0;
      held_dropped = 1'b0;
    end
  endtask

  // Offer one element and hold it until the block takes it.
  task automatic send_item(input in_t item, input bit has_lit, input out_t lit);
    start <= 1'b1;
    in_i  <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    take_element(item);
    if (has_lit) begin
      void'(sorted_q.pop_back());
      sorted_q.push_back(lit);
    end
  endtask

  // Drop start for a while, with junk on the data lines.
  task automatic idle_for(input int cycles);
    in_t junk;
    junk.value = $urandom;
    junk.last  = 1'($urandom_range(0, 1));
    start <= 1'b0;
    in_i  <= junk;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold the sender back until every pending result has come out.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value(input int mode);
    logic signed [DATA_WIDTH-1:0] v;
    case (mode)
      0: begin
        v = $urandom;
      end
      1: begin
        v = $signed($urandom_range(0, 15)) - 8;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          3: v = '1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic row_t mk_row(input logic signed [DATA_WIDTH-1:0] v, input bit last,
                                  input bit has_lit, input bit lit_last, input bit lit_ovf);
    row_t r;
    r.item.value    = v;
    r.item.last     = last;
    r.has_lit       = has_lit;
    r.lit.value_res = v;
    r.lit.last_res  = lit_last;
    r.lit.overflow  = lit_ovf;
    return r;
  endfunction

  // Stimulus: reset, directed table, then random batches.
  initial begin
    row_t rows[$];
    in_t  item;
    int   sent;
    int   batch;
    int   size;
    int   mode;
    int   pick;
    bit   quiet;

    sent = 0;
    // Single-element batches whose result is plain to see.
    rows.push_back(mk_row(VAL_MIN, 1'b1, 1'b1, 1'b1, 1'b0));
    rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b1, 1'b1, 1'b0));
    rows.push_back(mk_row('0,      1'b1, 1'b1, 1'b1, 1'b0));
    rows.push_back(mk_row('1,      1'b1, 1'b1, 1'b1, 1'b0));
    // Mixed extremes.
    rows.push_back(mk_row(VAL_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(VAL_MIN, 1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row('1,      1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row('0,      1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(1,       1'b1, 1'b0, 1'b0, 1'b0));
    // Duplicates.
    rows.push_back(mk_row(5,       1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(-5,      1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(5,       1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(-5,      1'b1, 1'b0, 1'b0, 1'b0));
    // Descending order.
    rows.push_back(mk_row(100,     1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(50,      1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(-50,     1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(-100,    1'b1, 1'b0, 1'b0, 1'b0));
    // Already sorted, equal extremes, alternating bit patterns.
    rows.push_back(mk_row(VAL_MIN, 1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(VAL_MAX, 1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(mk_row(32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].has_lit, rows[i].lit);
      sent++;
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 16));
    end

    // Random batches: mostly small, some near, at or beyond capacity.
    batch = 0;
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) size = $urandom_range(1, 8);
      else if (pick < 9) size = $urandom_range(9, 32);
      else size = $urandom_range(MAX_ITEMS - 8, MAX_ITEMS + 8);
      if (batch == 0) size = MAX_ITEMS;
      else if (batch == 1) size = MAX_ITEMS + 1;
      mode  = $urandom_range(0, 2);
      quiet = (sent > ITEM_TARGET - 60) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < size; k++) begin
        item.value = pick_value(mode);
        item.last  = (k == size - 1);
        send_item(item, 1'b0, '0);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 16));
      end
      if (batch == 3 || (sent <= ITEM_TARGET - 60 && $urandom_range(0, 9) == 0)) begin
        drain_results();
      end
      batch++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      $error("sorted results still pending: %0d", sorted_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Compare each result transaction with the oldest pending sorted element.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (sorted_q.size() == 0) begin
        $error("value_res: expected no result, actual %0d", res_o.value_res);
        mismatch_cnt++;
      end else begin
        want = sorted_q.pop_front();
        if (res_o.value_res !== want.value_res) begin
          $error("value_res: expected %0d, actual %0d", want.value_res, res_o.value_res);
          mismatch_cnt++;
        end
        if (res_o.last_res !== want.last_res) begin
          $error("last_res: expected %0b, actual %0b", want.last_res, res_o.last_res);
          mismatch_cnt++;
        end
        if (res_o.overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, res_o.overflow);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule
